FILE: rtl/core/soundex_stream_encoder_defines.svh
// Assertion macros shared by the Soundex stream encoder RTL.
`ifndef SOUNDEX_STREAM_ENCODER_DEFINES_SVH
`define SOUNDEX_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SDX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sdx_pkg.sv
// Constants, types and the letter-to-digit table of the Soundex stream encoder.
package sdx_pkg;

  localparam int MIN_LENGTH = 4;
  localparam int CHAR_W = 8;
  localparam int DIG_W = 3;
  localparam int CNT_W = 4;
  localparam int PAD_W = (MIN_LENGTH > 2) ? $clog2(MIN_LENGTH) : 1;

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_LENGTH);

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
    logic [PAD_W-1:0]  pad;
  } sdx_desc_t;

  function automatic logic [DIG_W-1:0] sdx_digit(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] lc;
    logic [DIG_W-1:0]  d;
    lc = ch | CASE_BIT;
    case (lc) inside
      "b", "f", "p", "v":                     d = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
      "d", "t":                               d = 3'd3;
      "l":                                    d = 3'd4;
      "m", "n":                               d = 3'd5;
      "r":                                    d = 3'd6;
      default:                                d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/sdx_if.sv
// Valid/ready channel interfaces for input bytes and code characters.
interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_first;

  modport source (output valid, output in_char, output is_first, input ready);
  modport sink (input valid, input in_char, input is_first, output ready);
endinterface

interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink (input valid, input out_char, input is_last, output ready);
endinterface

FILE: rtl/core/sdx_encode.sv
// Input register, code state and per-byte encoding into an output descriptor.
module sdx_encode (
  input  logic               clk,
  input  logic               rst_n,
  sdx_in_if.sink             in_if,
  output logic               desc_valid,
  input  logic               desc_ready,
  output sdx_pkg::sdx_desc_t desc
);

  logic                            in_v_r;
  logic [sdx_pkg::CHAR_W-1:0]      chr_r;
  logic                            first_r;
  logic [sdx_pkg::DIG_W-1:0]       ld_r;
  logic [sdx_pkg::DIG_W-1:0]       ld_nxt;
  logic [sdx_pkg::CNT_W-1:0]       cnt_r;
  logic [sdx_pkg::CNT_W-1:0]       cnt_nxt;
  logic [sdx_pkg::DIG_W-1:0]       dig;
  logic                            has_res;
  logic                            adv;
  logic                            take;

  assign dig = sdx_pkg::sdx_digit(chr_r);

  always_comb begin
    has_res = 1'b0;
    ld_nxt = ld_r;
    cnt_nxt = cnt_r;
    desc.chr = sdx_pkg::CHAR_NUL;
    desc.last = 1'b0;
    desc.pad = '0;
    if (first_r) begin
      ld_nxt = '0;
      has_res = 1'b1;
      if (chr_r == sdx_pkg::CHAR_NUL) begin
        desc.last = 1'b1;
        cnt_nxt = '0;
      end else begin
        desc.chr = (chr_r >= "a" && chr_r <= "z") ? (chr_r & ~sdx_pkg::CASE_BIT) : chr_r;
        cnt_nxt = 4'd1;
      end
    end else if (chr_r == sdx_pkg::CHAR_NUL) begin
      has_res = 1'b1;
      desc.last = 1'b1;
      if (cnt_r != '0 && cnt_r < sdx_pkg::CNT_MIN) begin
        desc.pad = sdx_pkg::PAD_W'(sdx_pkg::CNT_MIN - cnt_r);
      end
      ld_nxt = '0;
      cnt_nxt = '0;
    end else if (cnt_r != '0 && dig != '0 && dig != ld_r) begin
      has_res = 1'b1;
      desc.chr = sdx_pkg::CHAR_ZERO + sdx_pkg::CHAR_W'(dig);
      ld_nxt = dig;
      cnt_nxt = (cnt_r == sdx_pkg::CNT_MAX) ? cnt_r : cnt_r + 4'd1;
    end
  end

  assign desc_valid = in_v_r && has_res;
  assign adv = in_v_r && (!has_res || desc_ready);
  assign in_if.ready = !in_v_r || adv;
  assign take = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      ld_r <= '0;
      cnt_r <= '0;
    end else begin
      if (take) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        ld_r <= ld_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chr_r <= in_if.in_char;
      first_r <= in_if.is_first;
    end
  end

endmodule

FILE: rtl/core/sdx_serial.sv
// Output register that plays out pad digits and then the held character.
module sdx_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_valid,
  output logic               desc_ready,
  input  sdx_pkg::sdx_desc_t desc,
  sdx_out_if.source          out_if
);

  logic                          ov_r;
  logic [sdx_pkg::CHAR_W-1:0]    chr_r;
  logic                          last_r;
  logic [sdx_pkg::PAD_W-1:0]     pad_r;
  logic                          pad_on;

  assign pad_on = pad_r != '0;
  assign desc_ready = !ov_r || (!pad_on && out_if.ready);

  assign out_if.valid = ov_r;
  assign out_if.out_char = pad_on ? sdx_pkg::CHAR_ZERO : chr_r;
  assign out_if.is_last = !pad_on && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      pad_r <= '0;
    end else if (desc_valid && desc_ready) begin
      ov_r <= 1'b1;
      pad_r <= desc.pad;
    end else if (ov_r && out_if.ready) begin
      if (pad_on) begin
        pad_r <= pad_r - 1'b1;
      end else begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      chr_r <= desc.chr;
      last_r <= desc.last;
    end
  end

endmodule

FILE: rtl/core/soundex_stream_encoder.sv
// Top level of the streaming Soundex encoder.
//  channel  | direction | payload             | handshake
//  in_if    | input     | in_char, is_first   | valid / ready
//  out_if   | output    | out_char, is_last   | valid / ready
// A byte is encoded in the cycle after it is taken, and one byte is taken every cycle unless a stalled output holds it.
// Each code character leaves the output register one per cycle while out_if.ready is high.
// A terminator plays out up to MIN_LENGTH - 1 pad digits before the zero byte,
// holding back a waiting byte that yields a character until they are out.
// Reset is synchronous; it empties both registers and clears the code state.
// A stalled output holds the input only when the waiting byte yields a character.
`include "soundex_stream_encoder_defines.svh"

module soundex_stream_encoder (
  input  logic      clk,
  input  logic      rst_n,
  sdx_in_if.sink    in_if,
  sdx_out_if.source out_if
);

  logic               desc_valid;
  logic               desc_ready;
  sdx_pkg::sdx_desc_t desc;

  sdx_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  sdx_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .out_if     (out_if)
  );

  `SDX_ASSERT_IMP(a_last_is_nul, out_if.valid && out_if.is_last,
                  out_if.out_char == sdx_pkg::CHAR_NUL, "terminator is not a zero byte")
  `SDX_ASSERT_NXT(a_desc_lands, desc_valid && desc_ready, out_if.valid,
                  "loaded item did not reach the output")
  `SDX_ASSERT_IMP(a_ready_free, !desc_valid, in_if.ready, "input stalled with nothing to emit")

endmodule
